/* src/rv32i_alu_with_result_routing_defines.svh */
// Assertion macros shared by the execution unit.
`ifndef RV32I_ALU_WITH_RESULT_ROUTING_DEFINES_SVH
`define RV32I_ALU_WITH_RESULT_ROUTING_DEFINES_SVH

// A property checked on every rising clock edge while the unit is out of reset.
`define RV_ALU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A property checked on every rising clock edge, reset included.
`define RV_ALU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/rv_alu_pkg.sv */
`timescale 1ns / 1ps

package rv_alu_pkg;

  typedef enum logic [5:0] {
    CmdNone  = 6'd0,
    CmdAdd   = 6'd1,
    CmdSub   = 6'd2,
    CmdAnd   = 6'd3,
    CmdOr    = 6'd4,
    CmdXor   = 6'd5,
    CmdSll   = 6'd6,
    CmdSrl   = 6'd7,
    CmdSra   = 6'd8,
    CmdSlt   = 6'd9,
    CmdSltu  = 6'd10,
    CmdAddi  = 6'd11,
    CmdAndi  = 6'd12,
    CmdOri   = 6'd13,
    CmdXori  = 6'd14,
    CmdSlli  = 6'd15,
    CmdSrli  = 6'd16,
    CmdSrai  = 6'd17,
    CmdSlti  = 6'd18,
    CmdSltiu = 6'd19,
    CmdLb    = 6'd20,
    CmdLbu   = 6'd21,
    CmdLh    = 6'd22,
    CmdLhu   = 6'd23,
    CmdLw    = 6'd24,
    CmdSb    = 6'd25,
    CmdSh    = 6'd26,
    CmdSw    = 6'd27,
    CmdBeq   = 6'd28,
    CmdBge   = 6'd29,
    CmdBgeu  = 6'd30,
    CmdBlt   = 6'd31,
    CmdBltu  = 6'd32,
    CmdBne   = 6'd33,
    CmdJalr  = 6'd34,
    CmdLui   = 6'd35,
    CmdAuipc = 6'd36,
    CmdJal   = 6'd37
  } cmd_e;

  typedef struct packed {
    logic [5:0]         cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [4:0]         dest_tag;
    logic               flush;
  } alu_req_t;

  typedef struct packed {
    logic               rob_valid;
    logic               rs_valid;
    logic               lsb_valid;
    logic [5:0]         result_op;
    logic signed [31:0] result_value;
    logic [4:0]         result_tag;
    logic               redirect_valid;
    logic               illegal_op;
  } alu_rsp_t;

endpackage

/* src/rv_alu_stage.sv */
`timescale 1ns / 1ps

module rv_alu_stage #(
  parameter type data_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  data_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output data_t data_o
);

  logic  valid_q, valid_d;
  data_t data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* src/rv_alu_exec.sv */
`timescale 1ns / 1ps

module rv_alu_exec
  import rv_alu_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [31:0] a, b;
  logic [4:0]  sh;
  logic [31:0] sum, diff, value;
  logic        lt_s, lt_u, eq;
  logic        ill;
  logic        rob, rs, lsb, redir;

  assign a    = req_i.operand_a;
  assign b    = req_i.operand_b;
  assign sh   = b[4:0];
  assign sum  = a + b;
  assign diff = a - b;
  assign lt_s = $signed(a) < $signed(b);
  assign lt_u = a < b;
  assign eq   = a == b;

  always_comb begin
    value = '0;
    ill   = 1'b0;
    rob   = 1'b0;
    rs    = 1'b0;
    lsb   = 1'b0;
    redir = 1'b0;
    unique case (req_i.cmd)
      CmdNone: begin
      end
      CmdAdd, CmdAddi: begin
        value = sum;
        {rob, rs, lsb} = 3'b111;
      end
      CmdSub: begin
        value = diff;
        {rob, rs, lsb} = 3'b111;
      end
      CmdAnd, CmdAndi: begin
        value = a & b;
        {rob, rs, lsb} = 3'b111;
      end
      CmdOr, CmdOri: begin
        value = a | b;
        {rob, rs, lsb} = 3'b111;
      end
      CmdXor, CmdXori: begin
        value = a ^ b;
        {rob, rs, lsb} = 3'b111;
      end
      CmdSll, CmdSlli: begin
        value = a << sh;
        {rob, rs, lsb} = 3'b111;
      end
      CmdSrl, CmdSrli: begin
        value = a >> sh;
        {rob, rs, lsb} = 3'b111;
      end
      CmdSra, CmdSrai: begin
        value = $unsigned($signed(a) >>> sh);
        {rob, rs, lsb} = 3'b111;
      end
      CmdSlt, CmdSlti: begin
        value = {31'd0, lt_s};
        {rob, rs, lsb} = 3'b111;
      end
      CmdSltu, CmdSltiu: begin
        value = {31'd0, lt_u};
        {rob, rs, lsb} = 3'b111;
      end
      CmdLui, CmdAuipc, CmdJal: begin
        value = sum;
        {rob, rs, lsb} = 3'b111;
      end
      CmdLb, CmdLbu, CmdLh, CmdLhu, CmdLw: begin
        value = sum;
        lsb   = 1'b1;
      end
      CmdSb, CmdSh, CmdSw: begin
        value = sum;
        rob   = 1'b1;
      end
      CmdBeq: begin
        value = {31'd0, eq};
        rob   = 1'b1;
      end
      CmdBne: begin
        value = {31'd0, !eq};
        rob   = 1'b1;
      end
      CmdBge: begin
        value = {31'd0, !lt_s};
        rob   = 1'b1;
      end
      CmdBgeu: begin
        value = {31'd0, !lt_u};
        rob   = 1'b1;
      end
      CmdBlt: begin
        value = {31'd0, lt_s};
        rob   = 1'b1;
      end
      CmdBltu: begin
        value = {31'd0, lt_u};
        rob   = 1'b1;
      end
      CmdJalr: begin
        value = sum;
        redir = 1'b1;
      end
      default: begin
        ill = 1'b1;
      end
    endcase
  end

  // A flushed request or an empty slot produces an all-zero response.
  always_comb begin
    rsp_o = '0;
    if (!req_i.flush && (req_i.cmd != CmdNone)) begin
      rsp_o.result_op  = req_i.cmd;
      rsp_o.illegal_op = ill;
      if (!ill) begin
        rsp_o.rob_valid      = rob;
        rsp_o.rs_valid       = rs;
        rsp_o.lsb_valid      = lsb;
        rsp_o.result_value   = value;
        rsp_o.result_tag     = req_i.dest_tag;
        rsp_o.redirect_valid = redir;
      end
    end
  end

endmodule

/* src/rv32i_alu_with_result_routing.sv */
`timescale 1ns / 1ps
// Execution unit for an out-of-order RV32I core.
// The request channel (req_valid_i, req_ready_o, req_i) carries one issued
// instruction: operation code, two operands, reorder buffer tag and flush bit.
// The response channel (rsp_valid_o, rsp_ready_i, rsp_o) returns exactly one
// response per request, in order, with the computed value and the valid bits
// for the reorder buffer, reservation stations and load/store buffer.
// Flushed or empty requests return an all-zero response; unknown codes set
// illegal_op. A request is registered in the input stage, computed in
// combinational logic and registered again in the output stage, which
// offers the response. Throughput is one request per cycle while the
// receiver does not stall, set by the two pipeline registers.
// When the receiver stalls, the output register holds its response and the
// input register can still take one more request before req_ready_o drops.
// Reset empties both registers; no response is pending after reset.
`include "rv32i_alu_with_result_routing_defines.svh"

module rv32i_alu_with_result_routing
  import rv_alu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  alu_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output alu_rsp_t rsp_o
);

  logic     ex_valid, ex_ready;
  alu_req_t ex_req;
  alu_rsp_t ex_rsp;

  rv_alu_stage #(
    .data_t(alu_req_t)
  ) u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(req_valid_i),
    .ready_o(req_ready_o),
    .data_i (req_i),
    .valid_o(ex_valid),
    .ready_i(ex_ready),
    .data_o (ex_req)
  );

  rv_alu_exec u_exec (
    .req_i(ex_req),
    .rsp_o(ex_rsp)
  );

  rv_alu_stage #(
    .data_t(alu_rsp_t)
  ) u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(ex_valid),
    .ready_o(ex_ready),
    .data_i (ex_rsp),
    .valid_o(rsp_valid_o),
    .ready_i(rsp_ready_i),
    .data_o (rsp_o)
  );

  `RV_ALU_ASSERT(a_exec_advances, ex_valid && ex_ready |=> rsp_valid_o,
                 "Executed request did not reach the output register.")
  `RV_ALU_ASSERT(a_redirect_alone,
                 rsp_valid_o && rsp_o.redirect_valid |->
                 !rsp_o.rob_valid && !rsp_o.rs_valid && !rsp_o.lsb_valid,
                 "Redirect response also targets a consumer.")
  `RV_ALU_ASSERT(a_illegal_quiet,
                 rsp_valid_o && rsp_o.illegal_op |->
                 rsp_o.result_value == '0 && !rsp_o.redirect_valid &&
                 !rsp_o.rob_valid && !rsp_o.rs_valid && !rsp_o.lsb_valid,
                 "Illegal response carries a result.")
  `RV_ALU_ASSERT_ALWAYS(a_reset_empty, $rose(rst_ni) |-> !rsp_valid_o && !ex_valid,
                        "Pipeline holds a response when reset is released.")

endmodule
